/* design/tkd_pkg.sv */
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared types and constants for the terminal key decoder: decoder state,
// mode codes, special byte values and editing key codes.
// ----------------------------------------------------------------------------
package tkd_pkg;

  localparam int unsigned KeyWidth   = 21;
  localparam int unsigned ParamWidth = 16;

  localparam logic [KeyWidth-1:0] CP_MAX = 21'h10FFFF;

  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_RIGHT  = 8'h43;
  localparam logic [7:0] CH_LEFT   = 8'h44;

  localparam logic [KeyWidth-1:0] KEY_HOME  = 21'h01;
  localparam logic [KeyWidth-1:0] KEY_LEFT  = 21'h02;
  localparam logic [KeyWidth-1:0] KEY_END   = 21'h05;
  localparam logic [KeyWidth-1:0] KEY_RIGHT = 21'h06;
  localparam logic [KeyWidth-1:0] KEY_BKSP  = 21'h08;
  localparam logic [KeyWidth-1:0] KEY_DOWN  = 21'h0E;
  localparam logic [KeyWidth-1:0] KEY_UP    = 21'h10;

  localparam logic [ParamWidth-1:0] PARAM_HOME  = 16'd1;
  localparam logic [ParamWidth-1:0] PARAM_DEL   = 16'd3;
  localparam logic [ParamWidth-1:0] PARAM_END   = 16'd4;
  localparam logic [ParamWidth-1:0] PARAM_PGUP  = 16'd5;
  localparam logic [ParamWidth-1:0] PARAM_PGDN  = 16'd6;
  localparam logic [ParamWidth-1:0] PARAM_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic [ParamWidth-1:0]  first_param;
    logic [1:0]             param_count;
    logic [KeyWidth-1:0]    utf8_acc;
    logic [1:0]             utf8_remaining;
  } tkd_state_t;

endpackage

/* design/tkd_step.sv */
// ----------------------------------------------------------------------------
// tkd_step
// Combinational decode of one byte: next decoder state and an optional key.
// ----------------------------------------------------------------------------
module tkd_step
  import tkd_pkg::*;
(
  input  tkd_state_t           cur,
  input  logic [7:0]           rx_byte,
  output tkd_state_t           nxt,
  output logic                 got,
  output logic [KeyWidth-1:0]  code
);

  logic                       cont;
  logic [KeyWidth-1:0]        shifted;
  logic [1:0]                 rem_dec;
  logic [KeyWidth-1:0]        u_acc;
  logic [1:0]                 u_rem;
  logic                       u_got;
  logic [KeyWidth-1:0]        u_code;
  logic [ParamWidth+3:0]      param_sum;
  logic                       csi_got;
  logic [KeyWidth-1:0]        csi_code;

  assign cont      = (rx_byte[7:6] == 2'b10);
  assign shifted   = {cur.utf8_acc[KeyWidth-7:0], rx_byte[5:0]};
  assign rem_dec   = cur.utf8_remaining - 2'd1;
  assign param_sum = ({4'b0, cur.first_param} << 3) + ({4'b0, cur.first_param} << 1)
                   + {{(ParamWidth){1'b0}}, rx_byte[3:0]};

  always_comb begin
    u_acc  = '0;
    u_rem  = '0;
    u_got  = 1'b0;
    u_code = '0;
    if ((cur.utf8_remaining != 2'd0) && cont) begin
      if (rem_dec != 2'd0) begin
        u_acc = shifted;
        u_rem = rem_dec;
      end else if (shifted <= CP_MAX) begin
        u_got  = 1'b1;
        u_code = shifted;
      end
    end else begin
      if (cur.utf8_remaining == 2'd0) begin
        u_acc = cur.utf8_acc;
      end
      if (rx_byte[7] == 1'b0) begin
        u_got  = 1'b1;
        u_code = {{(KeyWidth-8){1'b0}}, rx_byte};
      end else if (rx_byte inside {[8'hC0:8'hDF]}) begin
        u_acc = {{(KeyWidth-5){1'b0}}, rx_byte[4:0]};
        u_rem = 2'd1;
      end else if (rx_byte inside {[8'hE0:8'hEF]}) begin
        u_acc = {{(KeyWidth-4){1'b0}}, rx_byte[3:0]};
        u_rem = 2'd2;
      end else if (rx_byte inside {[8'hF0:8'hF7]}) begin
        u_acc = {{(KeyWidth-3){1'b0}}, rx_byte[2:0]};
        u_rem = 2'd3;
      end
    end
  end

  // the final byte itself ends a parameter: exactly one parameter means none ended before it
  always_comb begin
    csi_got  = 1'b1;
    csi_code = '0;
    case (rx_byte)
      CH_UP:    csi_code = KEY_UP;
      CH_DOWN:  csi_code = KEY_DOWN;
      CH_RIGHT: csi_code = KEY_RIGHT;
      CH_LEFT:  csi_code = KEY_LEFT;
      CH_TILDE: begin
        if (cur.param_count != 2'd0) begin
          csi_got = 1'b0;
        end else begin
          case (cur.first_param)
            PARAM_HOME: csi_code = KEY_HOME;
            PARAM_DEL:  csi_code = KEY_BKSP;
            PARAM_END:  csi_code = KEY_END;
            PARAM_PGUP: csi_code = KEY_UP;
            PARAM_PGDN: csi_code = KEY_DOWN;
            default:    csi_got  = 1'b0;
          endcase
        end
      end
      default: csi_got = 1'b0;
    endcase
  end

  always_comb begin
    nxt  = cur;
    got  = 1'b0;
    code = '0;
    case (cur.mode)
      MODE_NORMAL: begin
        if (rx_byte == CH_ESC) begin
          nxt.mode = MODE_ESC;
        end else if (rx_byte == CH_DEL) begin
          got  = 1'b1;
          code = KEY_BKSP;
        end else begin
          nxt.utf8_acc       = u_acc;
          nxt.utf8_remaining = u_rem;
          got                = u_got;
          code               = u_code;
        end
      end
      MODE_ESC: begin
        if (rx_byte == CH_LBRACK) begin
          nxt.first_param = '0;
          nxt.param_count = '0;
          nxt.mode        = MODE_CSI;
        end else begin
          nxt.mode = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
          if (cur.param_count == 2'd0) begin
            nxt.first_param = (param_sum > {4'b0, PARAM_MAX}) ? PARAM_MAX
                                                               : param_sum[ParamWidth-1:0];
          end
        end else begin
          if (cur.param_count != 2'd2) begin
            nxt.param_count = cur.param_count + 2'd1;
          end
          if (rx_byte != CH_SEMI) begin
            nxt.mode = MODE_NORMAL;
            got      = csi_got;
            code     = csi_code;
          end
        end
      end
      default: nxt.mode = MODE_NORMAL;
    endcase
  end

endmodule

/* design/terminal_key_decoder_core.sv */
// ----------------------------------------------------------------------------
// terminal_key_decoder_core
// Turns received terminal bytes into key codes: UTF-8 code points, and
// editing codes for DEL and for CSI cursor and editing sequences.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while rx_stall is low, and gives at most one
// key code per byte. A byte lands in an input register, is decoded against the
// decoder state by the combinational step, and its key code, if any, is then
// registered in the result register together with key_valid. The rate is one
// byte per cycle while not stalled, set by the combinational decode step;
// rx_stall rises only while a key code waits under key_stall and a byte sits
// in the input register.
module terminal_key_decoder_core
  import tkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  output logic                 key_valid,
  input  logic                 key_stall,
  output logic [KeyWidth-1:0]  key_code
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  tkd_state_t           state;
  tkd_state_t           state_next;
  logic                 step_got;
  logic [KeyWidth-1:0]  step_code;
  logic                 out_free;
  logic                 s1_fire;

  tkd_step u_step (
    .cur     (state),
    .rx_byte (s1_byte),
    .nxt     (state_next),
    .got     (step_got),
    .code    (step_code)
  );

  assign out_free = !key_valid || !key_stall;
  assign s1_fire  = s1_valid && out_free;
  assign rx_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rx_stall) begin
      s1_valid <= rx_valid;
    end
    if (!rx_stall && rx_valid) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (out_free) begin
      key_valid <= s1_fire && step_got;
    end
    if (s1_fire && step_got) begin
      key_code <= step_code;
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> (s1_valid && key_valid && key_stall))
    else $error("input stalled without a held key code");

  a_key_follows_decode: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && step_got) |=> (key_valid && (key_code == $past(step_code))))
    else $error("decoded key code not captured");

  a_code_in_range: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> (key_code <= CP_MAX))
    else $error("key code beyond code point range");

  a_acc_clear_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state.utf8_remaining == 2'd0) |-> (state.utf8_acc == '0))
    else $error("UTF-8 accumulator not cleared with nothing pending");

endmodule
